// File: rtl/mck_pkg.sv
package mck_pkg;

    localparam int MAX_CHARS = 8;
    localparam int POS_W     = 4;
    localparam int DUR_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int SYM_W     = 5;
    localparam int LEN_W     = 3;
    localparam int NUM_LETTERS = 26;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_Z = 8'h5A;
    localparam logic [7:0] CHAR_0 = 8'h30;
    localparam logic [7:0] CHAR_9 = 8'h39;

    localparam logic [CFG_IDX_W-1:0] REG_DIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMGAP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LETGAP = 3'd3;

    localparam logic [DUR_W-1:0] RST_DIT    = 16'd100;
    localparam logic [DUR_W-1:0] RST_DAH    = 16'd300;
    localparam logic [DUR_W-1:0] RST_SYMGAP = 16'd100;
    localparam logic [DUR_W-1:0] RST_LETGAP = 16'd300;

    // what the datapath loads into the output register
    typedef enum logic [2:0] {
        K_PULSE  = 3'd0,
        K_GAP    = 3'd1,
        K_XGAP   = 3'd2,
        K_LETTER = 3'd3,
        K_CLOSE  = 3'd4
    } t_kind;

    typedef struct packed {
        logic  load_char;
        logic  emit;
        t_kind kind;
    } t_cmd;

    typedef struct packed {
        logic keyed_in;
        logic end_in;
        logic end_r;
        logic sym_last;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [SYM_W-1:0] bits;
    } t_rom_entry;

    // morse rom: a set bit is a dash, symbols sent from bit len-1 down
    function automatic t_rom_entry mck_rom(input logic [5:0] idx);
        t_rom_entry e;
        case (idx)
            6'd0:  e = '{3'd2, 5'd1};
            6'd1:  e = '{3'd4, 5'd8};
            6'd2:  e = '{3'd4, 5'd10};
            6'd3:  e = '{3'd3, 5'd4};
            6'd4:  e = '{3'd1, 5'd0};
            6'd5:  e = '{3'd4, 5'd2};
            6'd6:  e = '{3'd3, 5'd6};
            6'd7:  e = '{3'd4, 5'd0};
            6'd8:  e = '{3'd2, 5'd0};
            6'd9:  e = '{3'd4, 5'd7};
            6'd10: e = '{3'd3, 5'd5};
            6'd11: e = '{3'd4, 5'd4};
            6'd12: e = '{3'd2, 5'd3};
            6'd13: e = '{3'd2, 5'd2};
            6'd14: e = '{3'd3, 5'd7};
            6'd15: e = '{3'd4, 5'd6};
            6'd16: e = '{3'd4, 5'd13};
            6'd17: e = '{3'd3, 5'd2};
            6'd18: e = '{3'd3, 5'd0};
            6'd19: e = '{3'd1, 5'd1};
            6'd20: e = '{3'd3, 5'd1};
            6'd21: e = '{3'd4, 5'd1};
            6'd22: e = '{3'd3, 5'd3};
            6'd23: e = '{3'd4, 5'd9};
            6'd24: e = '{3'd4, 5'd11};
            6'd25: e = '{3'd4, 5'd12};
            6'd26: e = '{3'd5, 5'd31};
            6'd27: e = '{3'd5, 5'd15};
            6'd28: e = '{3'd5, 5'd7};
            6'd29: e = '{3'd5, 5'd3};
            6'd30: e = '{3'd5, 5'd1};
            6'd31: e = '{3'd5, 5'd0};
            6'd32: e = '{3'd5, 5'd16};
            6'd33: e = '{3'd5, 5'd24};
            6'd34: e = '{3'd5, 5'd28};
            6'd35: e = '{3'd5, 5'd30};
            default: e = '{3'd1, 5'd0};
        endcase
        return e;
    endfunction

endpackage

// File: rtl/mck_ctrl.sv
module mck_ctrl import mck_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ON     = 6'b000010,
        S_GAP    = 6'b000100,
        S_XGAP   = 6'b001000,
        S_LETTER = 6'b010000,
        S_CLOSE  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state         = r_state;
        o_cmd.load_char = accept;
        o_cmd.emit      = 1'b0;
        o_cmd.kind      = K_PULSE;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_st.keyed_in) begin
                        n_state = S_ON;
                    end else if (i_st.end_in) begin
                        n_state = S_CLOSE;
                    end
                end
            end
            S_ON: begin
                o_cmd.kind = K_PULSE;
                o_cmd.emit = i_st.out_free;
                if (i_st.out_free) begin
                    n_state = S_GAP;
                end
            end
            S_GAP: begin
                o_cmd.kind = K_GAP;
                o_cmd.emit = i_st.out_free;
                if (i_st.out_free) begin
                    n_state = i_st.sym_last ? S_LETTER : S_XGAP;
                end
            end
            S_XGAP: begin
                o_cmd.kind = K_XGAP;
                o_cmd.emit = i_st.out_free;
                if (i_st.out_free) begin
                    n_state = S_ON;
                end
            end
            S_LETTER: begin
                o_cmd.kind = K_LETTER;
                o_cmd.emit = i_st.out_free;
                if (i_st.out_free) begin
                    n_state = i_st.end_r ? S_CLOSE : S_IDLE;
                end
            end
            S_CLOSE: begin
                o_cmd.kind = K_CLOSE;
                o_cmd.emit = i_st.out_free;
                if (i_st.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/mck_dp.sv
module mck_dp import mck_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DUR_W-1:0]     i_cfg_data,
    input  logic [7:0]           i_char_code,
    input  logic                 i_message_end,
    input  logic                 i_out_stall,
    input  t_cmd                 i_cmd,
    output t_status              o_st,
    output logic                 o_out_valid,
    output logic                 o_tone_on,
    output logic [DUR_W-1:0]     o_interval_ms,
    output logic [2:0]           o_display_digit,
    output logic                 o_display_enable,
    output logic                 o_last
);

    logic [DUR_W-1:0] r_dit, r_dah, r_symgap, r_letgap;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [SYM_W-1:0] r_shift;
    logic [LEN_W-1:0] r_left;
    logic [2:0]       r_digit;
    logic             r_end;
    logic             r_valid;

    logic             is_letter, is_digit, in_range;
    logic [7:0]       off_a, off_0;
    logic [5:0]       rom_idx;
    t_rom_entry       rom_e;
    logic [POS_W-1:0] digit_full;
    logic [2:0]       digit_in;
    logic [SYM_W-1:0] shift_in;

    logic             n_tone, n_en, n_last;
    logic [DUR_W-1:0] n_dur;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dit    <= RST_DIT;
            r_dah    <= RST_DAH;
            r_symgap <= RST_SYMGAP;
            r_letgap <= RST_LETGAP;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DIT:    r_dit    <= i_cfg_data;
                REG_DAH:    r_dah    <= i_cfg_data;
                REG_SYMGAP: r_symgap <= i_cfg_data;
                REG_LETGAP: r_letgap <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // character decode
    assign is_letter = (i_char_code >= CHAR_A) && (i_char_code <= CHAR_Z);
    assign is_digit  = (i_char_code >= CHAR_0) && (i_char_code <= CHAR_9);
    assign off_a     = i_char_code - CHAR_A;
    assign off_0     = i_char_code - CHAR_0;
    assign rom_idx   = is_letter ? off_a[5:0] : (6'(NUM_LETTERS) + off_0[5:0]);
    assign rom_e     = mck_rom(rom_idx);
    assign in_range  = (r_pos < POS_W'(MAX_CHARS));
    assign digit_full = 4'd7 - r_pos;
    assign digit_in  = in_range ? digit_full[2:0] : 3'd0;
    // first symbol to the top bit
    assign shift_in  = rom_e.bits << (3'(SYM_W) - rom_e.len);

    always_comb begin
        n_pos = r_pos;
        if (i_message_end) begin
            n_pos = '0;
        end else if (in_range) begin
            n_pos = r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_cmd.load_char) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_char) begin
            r_shift <= shift_in;
            r_left  <= rom_e.len;
            r_digit <= digit_in;
            r_end   <= i_message_end;
        end else if (i_cmd.emit) begin
            if (i_cmd.kind == K_PULSE) begin
                r_shift <= {r_shift[SYM_W-2:0], 1'b0};
            end
            if (i_cmd.kind == K_GAP) begin
                r_left <= r_left - 1'b1;
            end
        end
    end

    // result selection
    always_comb begin
        n_tone = 1'b0;
        n_en   = 1'b1;
        n_last = 1'b0;
        n_dur  = r_symgap;
        unique case (i_cmd.kind) inside
            K_PULSE: begin
                n_tone = 1'b1;
                n_dur  = r_shift[SYM_W-1] ? r_dah : r_dit;
            end
            K_GAP, K_XGAP: n_dur = r_symgap;
            K_LETTER: begin
                n_dur  = r_letgap;
                n_last = !r_end;
            end
            K_CLOSE: begin
                n_dur  = '0;
                n_en   = 1'b0;
                n_last = 1'b1;
            end
            default: n_dur = r_symgap;
        endcase
    end

    assign o_st.keyed_in = in_range && (is_letter || is_digit);
    assign o_st.end_in   = i_message_end;
    assign o_st.end_r    = r_end;
    assign o_st.sym_last = (r_left == 3'd1);
    assign o_st.out_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_tone_on        <= n_tone;
            o_interval_ms    <= n_dur;
            o_display_digit  <= r_digit;
            o_display_enable <= n_en;
            o_last           <= n_last;
        end
    end

    assign o_out_valid = r_valid;

endmodule

// File: rtl/morse_code_keyer.sv
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+-------------------------------------
// input     | in        | i_in_valid / o_in_stall    | i_char_code, i_message_end
// result    | out       | o_out_valid / i_out_stall  | o_tone_on, o_interval_ms,
//           |           |                            | o_display_digit, o_display_enable,
//           |           |                            | o_last
// config    | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// a character is transferred first and then yields its results in order,
// at most 16 results per character
// the controller emits one result per cycle into a single output register,
// so a stall on the result side holds the sequencer in place
// o_in_stall is high from the transfer until the last result is loaded
// synchronous active-low reset clears state and position, reloads default timings
module morse_code_keyer import mck_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // character input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_char_code,
    input  logic                 i_message_end,
    // key interval output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_tone_on,
    output logic [DUR_W-1:0]     o_interval_ms,
    output logic [2:0]           o_display_digit,
    output logic                 o_display_enable,
    output logic                 o_last,
    // register writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DUR_W-1:0]     i_cfg_data
);

    t_cmd    cmd;
    t_status st;

    // registers are always writable
    assign o_cfg_ready = 1'b1;

    // sequencer: idle, dit/dah, symbol gap, extra gap, letter gap, closing
    mck_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    // rom lookup, position counter, timing registers, output register
    mck_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_char_code      (i_char_code),
        .i_message_end    (i_message_end),
        .i_out_stall      (i_out_stall),
        .i_cmd            (cmd),
        .o_st             (st),
        .o_out_valid      (o_out_valid),
        .o_tone_on        (o_tone_on),
        .o_interval_ms    (o_interval_ms),
        .o_display_digit  (o_display_digit),
        .o_display_enable (o_display_enable),
        .o_last           (o_last)
    );

endmodule

// File: rtl/mck_checker.sv
module mck_checker import mck_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic                 o_tone_on,
    input logic [DUR_W-1:0]     o_interval_ms,
    input logic [2:0]           o_display_digit,
    input logic                 o_display_enable,
    input logic                 o_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_tone_on)
            && $stable(o_interval_ms) && $stable(o_display_digit)
            && $stable(o_display_enable) && $stable(o_last))
        else $error("stalled result changed");

    // closing result is silent and ends the transfer sequence
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_display_enable |->
            o_last && !o_tone_on && (o_interval_ms == '0))
        else $error("malformed closing result");

    // a tone pulse is never marked last and is always followed by a gap
    a_pulse_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tone_on |-> !o_last && o_display_enable)
        else $error("tone pulse marked last");

    a_pulse_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tone_on && !i_out_stall |=> o_out_valid && !o_tone_on)
        else $error("no gap after tone pulse");

endmodule

bind morse_code_keyer mck_checker u_mck_checker (.*);
